// File: design/tcw_pkg.sv
// tcw_pkg: shared widths, action and character codes, register indexes
// and the command/status structs between controller and datapath
// no dependencies
`default_nettype none

package tcw_pkg;

  localparam int ACTION_W   = 2;
  localparam int CHAR_W     = 8;
  localparam int ADDR_IN_W  = 11;
  localparam int COL_OUT_W  = 7;
  localparam int ROW_OUT_W  = 5;
  localparam int OFFSET_W   = 11;
  localparam int ATTR_W     = 8;
  localparam int COLOR_W    = 4;
  localparam int CELL_W     = 16;
  localparam int CFG_IDX_W  = 1;

  typedef logic [ACTION_W-1:0] action_t;

  localparam action_t ACT_PUT   = 2'd0;
  localparam action_t ACT_CLEAR = 2'd1;
  localparam action_t ACT_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'd1;

  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;
  localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan_clr;
    logic scan_blank;
    logic scan_inc;
    logic copy_rd;
    logic blank_wr;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    action_t action;
    logic    scroll_req;
    logic    copy_last;
    logic    scan_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: design/tcw_in_if.sv
// tcw_in_if: input channel of the console writer (valid/ready plus item)
// depends on tcw_pkg
`default_nettype none

interface tcw_in_if;
  import tcw_pkg::*;

  logic                   valid;
  logic                   ready;
  action_t                action;
  logic [CHAR_W-1:0]      char_code;
  logic [ADDR_IN_W-1:0]   cell_address;

  modport source (output valid, output action, output char_code, output cell_address,
                  input ready);
  modport sink   (input valid, input action, input char_code, input cell_address,
                  output ready);
endinterface

`default_nettype wire

// File: design/tcw_out_if.sv
// tcw_out_if: result channel of the console writer (valid/ready plus result)
// depends on tcw_pkg
`default_nettype none

interface tcw_out_if;
  import tcw_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [COL_OUT_W-1:0]   cursor_col;
  logic [ROW_OUT_W-1:0]   cursor_row;
  logic [OFFSET_W-1:0]    cursor_offset;
  logic [CHAR_W-1:0]      cell_char;
  logic [ATTR_W-1:0]      cell_attr;

  modport source (output valid, output cursor_col, output cursor_row, output cursor_offset,
                  output cell_char, output cell_attr, input ready);
  modport sink   (input valid, input cursor_col, input cursor_row, input cursor_offset,
                  input cell_char, input cell_attr, output ready);
endinterface

`default_nettype wire

// File: design/tcw_ctrl.sv
// tcw_ctrl: sequencing state machine of the console writer
// depends on tcw_pkg; drives tcw_datapath through dp_cmd_t
`default_nettype none

module tcw_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire tcw_pkg::dp_sts_t sts,
  output tcw_pkg::dp_cmd_t      cmd
);
  import tcw_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_COPY  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_BLANK = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec     = 1'b1;
        cmd.scan_clr = 1'b1;
        if (sts.action == ACT_PUT && sts.scroll_req) begin
          state_nxt = S_COPY;
        end else if (sts.action == ACT_CLEAR) begin
          state_nxt = S_CLEAR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_COPY: begin
        cmd.copy_rd  = 1'b1;
        cmd.scan_inc = 1'b1;
        if (sts.copy_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        // last row copy lands this cycle
        cmd.scan_blank = 1'b1;
        state_nxt      = S_BLANK;
      end
      S_BLANK, S_CLEAR: begin
        cmd.blank_wr = 1'b1;
        cmd.scan_inc = 1'b1;
        if (sts.scan_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/tcw_datapath.sv
// tcw_datapath: screen memory, cursor, color registers and result register
// depends on tcw_pkg; commanded by tcw_ctrl
`default_nettype none

module tcw_datapath #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire tcw_pkg::dp_cmd_t                 cmd,
  output tcw_pkg::dp_sts_t                      sts,
  input  wire tcw_pkg::action_t                 in_action,
  input  wire logic [tcw_pkg::CHAR_W-1:0]       in_char_code,
  input  wire logic [tcw_pkg::ADDR_IN_W-1:0]    in_cell_address,
  input  wire logic                             cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tcw_pkg::COLOR_W-1:0]      cfg_wdata,
  output logic [tcw_pkg::COL_OUT_W-1:0]         out_cursor_col,
  output logic [tcw_pkg::ROW_OUT_W-1:0]         out_cursor_row,
  output logic [tcw_pkg::OFFSET_W-1:0]          out_cursor_offset,
  output logic [tcw_pkg::CHAR_W-1:0]            out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]            out_cell_attr
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS + TAB_STOP + 1);
  localparam int ROW_W      = $clog2(ROWS + 1);
  localparam int PH_W       = $clog2(TAB_STOP);

  localparam logic [COL_W-1:0]  COL_END    = COL_W'(COLUMNS);
  localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
  localparam logic [COL_W-1:0]  TAB_COL    = COL_W'(TAB_STOP);
  localparam logic [ROW_W-1:0]  ROW_END    = ROW_W'(ROWS);
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
  localparam logic [PH_W-1:0]   PH_LAST    = PH_W'(TAB_STOP - 1);
  localparam logic [PH_W-1:0]   BS_PHASE   = PH_W'((COLUMNS - 1) % TAB_STOP);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELL_COUNT - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] BLANK_BASE = ADDR_W'(CELL_COUNT - COLUMNS);
  localparam logic [ADDR_W-1:0] SCAN_LAST  = ADDR_W'(CELL_COUNT - 1);

  // latched item
  action_t                action_r;
  logic [CHAR_W-1:0]      char_r;
  logic [ADDR_IN_W-1:0]   addr_r;

  // cursor, with column phase inside the tab stop
  logic [COL_W-1:0]       col_r, col_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [PH_W-1:0]        ph_r, ph_nxt;
  logic                   scroll;
  logic                   put_wr;

  logic [COLOR_W-1:0]     bg_r, fg_r;
  logic [ATTR_W-1:0]      attr;

  logic [ADDR_W-1:0]      cnt_r, cnt_nxt;
  logic                   cp_vld_r;
  logic [ADDR_W-1:0]      cp_addr_r;

  logic [CELL_W-1:0]      mem [CELL_COUNT];
  logic [CELL_W-1:0]      rd_data_r;
  logic                   rd_hit_r;
  logic                   rd_hit;

  logic [ADDR_W-1:0]      pos;
  logic                   we, re;
  logic [ADDR_W-1:0]      wa, ra;
  logic [CELL_W-1:0]      wd;

  logic [COL_OUT_W-1:0]   out_col_r;
  logic [ROW_OUT_W-1:0]   out_row_r;
  logic [OFFSET_W-1:0]    out_off_r;
  logic [CHAR_W-1:0]      out_char_r;
  logic [ATTR_W-1:0]      out_attr_r;

  assign attr   = {bg_r, fg_r};
  assign pos    = ADDR_W'(row_r) * ROW_STRIDE + ADDR_W'(col_r);
  assign rd_hit = 32'(addr_r) < 32'(CELL_COUNT);

  // cursor update for a put
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    ph_nxt  = ph_r;
    scroll  = 1'b0;
    put_wr  = 1'b0;
    if (!char_r[CHAR_W-1]) begin
      if (char_r == CH_BS) begin
        if (col_r != '0) begin
          col_nxt = col_r - 1'b1;
          ph_nxt  = (ph_r == '0) ? PH_LAST : ph_r - 1'b1;
        end else if (row_r != '0) begin
          col_nxt = COL_LAST;
          ph_nxt  = BS_PHASE;
          row_nxt = row_r - 1'b1;
        end
      end else if (char_r == CH_TAB) begin
        col_nxt = col_r + TAB_COL - COL_W'(ph_r);
        ph_nxt  = '0;
      end else if (char_r == CH_CR) begin
        col_nxt = '0;
        ph_nxt  = '0;
      end else if (char_r == CH_LF) begin
        row_nxt = row_r + 1'b1;
      end else if (char_r >= CH_SPACE) begin
        put_wr  = 1'b1;
        col_nxt = col_r + 1'b1;
        ph_nxt  = (ph_r == PH_LAST) ? '0 : ph_r + 1'b1;
      end
      if (col_nxt >= COL_END) begin
        col_nxt = '0;
        ph_nxt  = '0;
        row_nxt = row_nxt + 1'b1;
      end
      if (row_nxt >= ROW_END) begin
        row_nxt = ROW_LAST;
        scroll  = 1'b1;
      end
    end
  end

  // memory port selection
  always_comb begin
    we = 1'b0;
    wa = pos;
    wd = {attr, char_r};
    if (cp_vld_r) begin
      we = 1'b1;
      wa = cp_addr_r;
      wd = rd_data_r;
    end else if (cmd.blank_wr) begin
      we = 1'b1;
      wa = cnt_r;
      wd = {attr, CH_SPACE};
    end else if (cmd.exec && action_r == ACT_PUT && put_wr) begin
      we = 1'b1;
    end
  end

  assign re = cmd.copy_rd || (cmd.exec && action_r == ACT_READ && rd_hit);
  assign ra = cmd.copy_rd ? cnt_r + ROW_STRIDE : ADDR_W'(addr_r);

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.scan_clr) begin
      cnt_nxt = '0;
    end else if (cmd.scan_blank) begin
      cnt_nxt = BLANK_BASE;
    end else if (cmd.scan_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (re) rd_data_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      ph_r     <= '0;
      bg_r     <= BG_RESET;
      fg_r     <= FG_RESET;
      cp_vld_r <= 1'b0;
      rd_hit_r <= 1'b0;
    end else begin
      cp_vld_r <= cmd.copy_rd;
      if (cmd.exec) begin
        case (action_r)
          ACT_PUT: begin
            col_r <= col_nxt;
            row_r <= row_nxt;
            ph_r  <= ph_nxt;
          end
          ACT_CLEAR: begin
            col_r <= '0;
            row_r <= '0;
            ph_r  <= '0;
          end
          default: ;
        endcase
        rd_hit_r <= (action_r == ACT_READ) && rd_hit;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BACKGROUND: bg_r <= cfg_wdata;
          CFG_FOREGROUND: fg_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    cp_addr_r <= cnt_r;
    if (cmd.load) begin
      action_r <= in_action;
      char_r   <= in_char_code;
      addr_r   <= in_cell_address;
    end
    if (cmd.out_load) begin
      out_col_r  <= COL_OUT_W'(col_r);
      out_row_r  <= ROW_OUT_W'(row_r);
      out_off_r  <= OFFSET_W'(pos);
      out_char_r <= rd_hit_r ? rd_data_r[CHAR_W-1:0] : '0;
      out_attr_r <= rd_hit_r ? rd_data_r[CELL_W-1:CHAR_W] : '0;
    end
  end

  assign sts.action     = action_r;
  assign sts.scroll_req = scroll;
  assign sts.copy_last  = (cnt_r == COPY_LAST);
  assign sts.scan_last  = (cnt_r == SCAN_LAST);

  assign out_cursor_col    = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_offset = out_off_r;
  assign out_cell_char     = out_char_r;
  assign out_cell_attr     = out_attr_r;

endmodule

`default_nettype wire

// File: design/text_console_character_writer.sv
// text_console_character_writer: top level of the text console engine
// depends on tcw_pkg, tcw_in_if, tcw_out_if, tcw_ctrl, tcw_datapath
//
// usage
//   in_ch carries one item per transfer: put a character, clear the screen,
//   or read one cell. out_ch returns exactly one result per item: the cursor
//   after the item and, for a read inside the screen, the stored cell.
//   cfg_we/cfg_index/cfg_wdata set the background and foreground colors;
//   write them only while the block is idle.
// sequencing
//   put, read and other items pass through the controller's load, execute
//   and result-load states; a new item is taken only after the last one's
//   result is loaded. The screen memory has one write and one read port.
//   a put that scrolls: one memory copy per cycle, moving every row up by one,
//   plus one row of blanks. clear: one blank a cycle over the whole screen.
// reset
//   cursor goes home, colors to 0/7; screen contents stay unknown until
//   written (no clearing pass; issue a clear first).
// stall
//   a finished result sits in the output register; the next item is taken
//   meanwhile, and its result waits until the register is free.
`default_nettype none

module text_console_character_writer #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  tcw_in_if.sink                             in_ch,
  tcw_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tcw_pkg::COLOR_W-1:0]   cfg_wdata
);
  import tcw_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_action         (in_ch.action),
    .in_char_code      (in_ch.char_code),
    .in_cell_address   (in_ch.cell_address),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_cursor_col    (out_ch.cursor_col),
    .out_cursor_row    (out_ch.cursor_row),
    .out_cursor_offset (out_ch.cursor_offset),
    .out_cell_char     (out_ch.cell_char),
    .out_cell_attr     (out_ch.cell_attr)
  );

endmodule

`default_nettype wire

// File: design/tcw_checker.sv
// tcw_checker: port-level assertions for the console writer, with its bind
// depends on tcw_pkg and text_console_character_writer
`default_nettype none

module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [tcw_pkg::COL_OUT_W-1:0]  out_cursor_col,
  input wire logic [tcw_pkg::ROW_OUT_W-1:0]  out_cursor_row,
  input wire logic [tcw_pkg::OFFSET_W-1:0]   out_cursor_offset
);
  import tcw_pkg::*;

  localparam bit FITS = (COLUMNS <= 128) && (ROWS <= 32) && (COLUMNS * ROWS <= 2048);
  localparam logic [OFFSET_W-1:0] COLS_OFF = OFFSET_W'(COLUMNS);

  // result held until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // one item in flight: busy right after an input transfer
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while item in progress");

  // reported offset matches reported row and column (checked when the screen fits the port widths)
  a_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && FITS |->
      out_cursor_offset == (OFFSET_W'(out_cursor_row) * COLS_OFF + OFFSET_W'(out_cursor_col)))
    else $error("cursor offset inconsistent");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind text_console_character_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_cursor_col    (out_ch.cursor_col),
  .out_cursor_row    (out_ch.cursor_row),
  .out_cursor_offset (out_ch.cursor_offset)
);

`default_nettype wire

// File: dv/text_console_character_writer_test.sv
// text_console_character_writer_test: self-checking bench for the text console writer
// keeps its own screen and cursor copy and checks every result transfer in order
// depends on tcw_pkg, tcw_in_if, tcw_out_if and the design top level
`timescale 1ns / 100ps

module text_console_character_writer_test;
  import tcw_pkg::*;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;
  localparam int CELLS    = COLUMNS * ROWS;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 9;
  localparam int IDLE_PCT      = 27;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 40;
  localparam int LIMIT_CYCLES  = 20_000_000;

  localparam action_t ACT_UNUSED = 2'd3;

  localparam logic [CHAR_W-1:0] CH_LAST_PRINT = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_FIRST_HIGH = 8'h80;

  typedef struct packed {
    logic [COL_OUT_W-1:0] cursor_col;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [OFFSET_W-1:0]  cursor_offset;
    logic [CHAR_W-1:0]    cell_char;
    logic [ATTR_W-1:0]    cell_attr;
  } console_status_t;

  bit clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0] cfg_wdata;

  tcw_in_if  in_ch();
  tcw_out_if out_ch();

  text_console_character_writer #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // screen and cursor copy
  logic [CELL_W-1:0] scr_cell [CELLS];
  bit                scr_known [CELLS];
  int                crs_col;
  int                crs_row;
  logic [COLOR_W-1:0] bg_color;
  logic [COLOR_W-1:0] fg_color;

  console_status_t cursor_cell_q[$];
  int  mismatches;
  int  cycle_count;
  bit  calm;

  always begin
    clk = 1'b0;
    #(HALF_PERIOD);
    clk = 1'b1;
    #(HALF_PERIOD);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic console_status_t apply_item(action_t act, logic [CHAR_W-1:0] code,
                                                 logic [ADDR_IN_W-1:0] addr);
    console_status_t st;
    logic [CELL_W-1:0] blank;
    int pos;
    int i;
    st = '0;
    blank = {bg_color, fg_color, CH_SPACE};
    if (act == ACT_PUT && code < CH_FIRST_HIGH) begin
      if (code == CH_BS) begin
        if (crs_col != 0) begin
          crs_col--;
        end else if (crs_row != 0) begin
          crs_col = COLUMNS - 1;
          crs_row--;
        end
      end else if (code == CH_TAB) begin
        crs_col = crs_col + TAB_STOP - (crs_col % TAB_STOP);
      end else if (code == CH_CR) begin
        crs_col = 0;
      end else if (code == CH_LF) begin
        crs_row++;
      end else if (code >= CH_SPACE) begin
        pos = crs_row * COLUMNS + crs_col;
        scr_cell[pos] = {blank[CELL_W-1:CHAR_W], code};
        scr_known[pos] = 1'b1;
        crs_col++;
      end
      if (crs_col >= COLUMNS) begin
        crs_col = 0;
        crs_row++;
      end
      if (crs_row >= ROWS) begin
        crs_row = ROWS - 1;
        for (i = 0; i < CELLS - COLUMNS; i++) begin
          scr_cell[i] = scr_cell[i + COLUMNS];
          scr_known[i] = scr_known[i + COLUMNS];
        end
        for (i = CELLS - COLUMNS; i < CELLS; i++) begin
          scr_cell[i] = blank;
          scr_known[i] = 1'b1;
        end
      end
    end else if (act == ACT_CLEAR) begin
      for (i = 0; i < CELLS; i++) begin
        scr_cell[i] = blank;
        scr_known[i] = 1'b1;
      end
      crs_col = 0;
      crs_row = 0;
    end else if (act == ACT_READ && addr < CELLS) begin
      st.cell_char = scr_cell[addr][CHAR_W-1:0];
      st.cell_attr = scr_cell[addr][CELL_W-1:CHAR_W];
    end
    st.cursor_col = COL_OUT_W'(crs_col);
    st.cursor_row = ROW_OUT_W'(crs_row);
    st.cursor_offset = OFFSET_W'(crs_row * COLUMNS + crs_col);
    return st;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    end
  endfunction

  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : check_results
    console_status_t got;
    console_status_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.cursor_col, out_ch.cursor_row, out_ch.cursor_offset,
             out_ch.cell_char, out_ch.cell_attr};
      if (cursor_cell_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result transfer with nothing expected, expected none actual %h",
                   $time, got);
        end
      end else begin
        want = cursor_cell_q.pop_front();
        compare_field("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
        compare_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
        compare_field("cursor_offset", 16'(want.cursor_offset), 16'(got.cursor_offset));
        compare_field("cell_char", 16'(want.cell_char), 16'(got.cell_char));
        compare_field("cell_attr", 16'(want.cell_attr), 16'(got.cell_attr));
      end
    end
  end

  // called at a falling edge, returns at a falling edge after the transfer
  task automatic drive_item(action_t act, logic [CHAR_W-1:0] code,
                            logic [ADDR_IN_W-1:0] addr);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.char_code <= code;
    in_ch.cell_address <= addr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    cursor_cell_q.push_back(apply_item(act, code, addr));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (cursor_cell_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_colors(logic [COLOR_W-1:0] bg, logic [COLOR_W-1:0] fg);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= CFG_BACKGROUND;
    cfg_wdata <= bg;
    bg_color = bg;
    @(negedge clk);
    cfg_index <= CFG_FOREGROUND;
    cfg_wdata <= fg;
    fg_color = fg;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] pick_put_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 66) return CHAR_W'($urandom_range(CH_SPACE, CH_LAST_PRINT));
    if (r < 72) return CH_LF;
    if (r < 78) return CH_BS;
    if (r < 84) return CH_TAB;
    if (r < 89) return CH_CR;
    if (r < 94) return CHAR_W'($urandom_range(0, CH_SPACE - 1));
    return CHAR_W'($urandom_range(CH_FIRST_HIGH, {CHAR_W{1'b1}}));
  endfunction

  // only cells already written, or addresses past the screen
  function automatic logic [ADDR_IN_W-1:0] pick_read_addr();
    logic [ADDR_IN_W-1:0] a;
    int k;
    if ($urandom_range(0, 9) != 0) begin
      for (k = 0; k < 16; k++) begin
        a = ADDR_IN_W'($urandom_range(0, CELLS - 1));
        if (scr_known[a]) return a;
      end
    end
    return ADDR_IN_W'($urandom_range(CELLS, (1 << ADDR_IN_W) - 1));
  endfunction

  task automatic drive_random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 79) begin
      drive_item(ACT_PUT, pick_put_code(), ADDR_IN_W'($urandom));
    end else if (r < 93) begin
      drive_item(ACT_READ, CHAR_W'($urandom), pick_read_addr());
    end else if (r < 95) begin
      drive_item(ACT_CLEAR, CHAR_W'($urandom), ADDR_IN_W'($urandom));
    end else begin
      drive_item(ACT_UNUSED, CHAR_W'($urandom), ADDR_IN_W'($urandom));
    end
  endtask

  // screen still unknown here, only cell 0 gets written
  task automatic test_before_clear();
    drive_item(ACT_READ, '0, '1);
    drive_item(ACT_UNUSED, '1, '1);
    drive_item(ACT_PUT, CH_BS, '0);
    drive_item(ACT_PUT, 8'h00, '0);
    drive_item(ACT_PUT, '1, '1);
    drive_item(ACT_PUT, CH_FIRST_HIGH, '0);
    drive_item(ACT_PUT, 8'h41, '0);
    drive_item(ACT_READ, '0, '0);
    drive_item(ACT_READ, '0, ADDR_IN_W'(CELLS));
  endtask

  task automatic test_controls();
    drive_item(ACT_CLEAR, '1, '1);
    drive_item(ACT_PUT, CH_SPACE, '0);
    drive_item(ACT_PUT, CH_LAST_PRINT, '0);
    drive_item(ACT_PUT, CH_TAB, '0);
    drive_item(ACT_PUT, CH_TAB, '0);
    drive_item(ACT_PUT, CH_CR, '0);
    drive_item(ACT_PUT, CH_LF, '0);
    drive_item(ACT_PUT, CH_BS, '0);
    drive_item(ACT_PUT, CH_TAB, '0);
    drive_item(ACT_PUT, CH_BS, '0);
    drive_item(ACT_PUT, 8'h5A, '0);
    drive_item(ACT_READ, '0, ADDR_IN_W'(COLUMNS - 1));
    drive_item(ACT_READ, '0, ADDR_IN_W'(COLUMNS));
    drive_item(ACT_PUT, CHAR_W'(CH_SPACE - 1), '0);
    drive_item(ACT_PUT, 8'h78, '0);
    drive_item(ACT_PUT, CH_LF, '0);
  endtask

  task automatic test_color_registers();
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] fg;
    logic [ADDR_IN_W-1:0] spot;
    int k;
    for (k = 0; k < 5; k++) begin
      case (k)
        0: begin bg = '1; fg = '0; end
        1: begin bg = '0; fg = '1; end
        2: begin bg = '1; fg = '1; end
        3: begin bg = '0; fg = '0; end
        default: begin
          bg = COLOR_W'($urandom);
          fg = COLOR_W'($urandom);
        end
      endcase
      set_colors(bg, fg);
      spot = ADDR_IN_W'(crs_row * COLUMNS + crs_col);
      drive_item(ACT_PUT, CHAR_W'($urandom_range(CH_SPACE, CH_LAST_PRINT)), '0);
      drive_item(ACT_READ, '0, spot);
      if (k == 2) begin
        drive_item(ACT_CLEAR, '0, '0);
      end
      drive_item(ACT_READ, '0, pick_read_addr());
      drive_item(ACT_UNUSED, CHAR_W'($urandom), ADDR_IN_W'($urandom));
    end
  endtask

  // cursor parked on the last row so text and line feeds push the screen up
  task automatic test_scroll();
    int n;
    int r;
    set_colors(COLOR_W'($urandom), COLOR_W'($urandom));
    drive_item(ACT_CLEAR, '0, '0);
    repeat (ROWS - 1) drive_item(ACT_PUT, CH_LF, ADDR_IN_W'($urandom));
    for (n = 0; n < 220; n++) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        drive_item(ACT_PUT, CHAR_W'($urandom_range(CH_SPACE, CH_LAST_PRINT)),
                   ADDR_IN_W'($urandom));
      end else if (r < 88) begin
        drive_item(ACT_PUT, CH_LF, ADDR_IN_W'($urandom));
      end else if (r < 91) begin
        drive_item(ACT_PUT, CH_CR, ADDR_IN_W'($urandom));
      end else begin
        drive_item(ACT_READ, CHAR_W'($urandom),
                   ADDR_IN_W'((ROWS - 2) * COLUMNS + $urandom_range(0, 2 * COLUMNS - 1)));
      end
    end
  endtask

  task automatic test_drain_pause();
    repeat (20) drive_random_item();
    wait_drained();
    repeat (20) drive_random_item();
  endtask

  task automatic test_random_traffic();
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] fg;
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin bg = '1; fg = '1; end
        1: begin bg = '0; fg = '0; end
        2: begin bg = '1; fg = '0; end
        3: begin bg = '0; fg = '1; end
        default: begin
          bg = COLOR_W'($urandom);
          fg = COLOR_W'($urandom);
        end
      endcase
      set_colors(bg, fg);
      // one phase runs with no idle cycles on either side
      calm = (phase == 3);
      repeat (270) drive_random_item();
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_PUT;
    in_ch.char_code = '0;
    in_ch.cell_address = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_BACKGROUND;
    cfg_wdata = '0;
    crs_col = 0;
    crs_row = 0;
    bg_color = BG_RESET;
    fg_color = FG_RESET;
    for (int i = 0; i < CELLS; i++) begin
      scr_cell[i] = '0;
      scr_known[i] = 1'b0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_before_clear();
    test_controls();
    test_color_registers();
    test_scroll();
    test_drain_pause();
    test_random_traffic();

    wait_drained();
    repeat (CELLS + 16) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/tcw_pkg.sv
design/tcw_in_if.sv
design/tcw_out_if.sv
design/tcw_ctrl.sv
design/tcw_datapath.sv
design/text_console_character_writer.sv
design/tcw_checker.sv
dv/text_console_character_writer_test.sv
